FILE: sv/catmull_rom_segment_coefficients_top_macros.svh
// Assertion macros for the Catmull-Rom segment coefficient block.
// Used by the port checker; no other dependencies.
`ifndef CATMULL_ROM_SEGMENT_COEFFICIENTS_TOP_MACROS_SVH
`define CATMULL_ROM_SEGMENT_COEFFICIENTS_TOP_MACROS_SVH

// Checked at every edge outside reset.
`define CRSC_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRSC_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/crsc_pkg.sv
// Shared types, constants and helpers for the Catmull-Rom coefficient block.
// No dependencies.
package crsc_pkg;

	localparam int COORD_W     = 24;
	localparam int EXT_W       = 27;
	localparam int COEF_W      = 32;
	localparam int IDX_W       = 6;
	localparam int NCOMP       = 4;
	localparam int COMP_W      = 2;
	localparam int NJOB        = 3;
	localparam int WIN_D       = 3;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_BITS    = IDX_W + 4 * COEF_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST  = 1'b1;
	localparam logic [IDX_W-1:0] FIRST_RST = 6'd0;
	localparam logic [IDX_W-1:0] LAST_RST  = 6'd63;
	localparam logic [COMP_W-1:0] LAST_COMP = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EXT_W-1:0]   ext_t;
	typedef logic signed [COEF_W-1:0]  word_t;

	typedef struct packed {
		ext_t p;
		ext_t c;
		ext_t n;
		ext_t nn;
	} lane_in_t;

	typedef struct packed {
		word_t cubic;
		word_t square;
		word_t linear;
		word_t constant;
	} coef_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
	} job_ctrl_t;

	function automatic ext_t sext(input coord_t a);
		return ext_t'(a);
	endfunction

	// 2a - b for positions, a for roll
	function automatic ext_t ext2(input coord_t a, input coord_t b, input logic roll);
		ext_t ea;
		ext_t eb;
		ea = ext_t'(a);
		eb = ext_t'(b);
		return roll ? ea : (ea <<< 1) - eb;
	endfunction

	// 3a - 2b for positions, a for roll
	function automatic ext_t ext3(input coord_t a, input coord_t b, input logic roll);
		ext_t ea;
		ext_t eb;
		ea = ext_t'(a);
		eb = ext_t'(b);
		return roll ? ea : (ea <<< 1) + ea - (eb <<< 1);
	endfunction

endpackage

FILE: sv/crsc_lane.sv
// One component lane: registers P, C, N, NN and forms the four coefficients.
// Depends on crsc_pkg.
module crsc_lane (
	input  logic              clk,
	input  logic              en,
	input  crsc_pkg::lane_in_t din,
	output crsc_pkg::coef_t    dout
);

	crsc_pkg::lane_in_t in_s1;
	crsc_pkg::word_t p, c, n, nn, cmn;

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= din;
		end
	end

	always_comb begin
		p   = crsc_pkg::word_t'(in_s1.p);
		c   = crsc_pkg::word_t'(in_s1.c);
		n   = crsc_pkg::word_t'(in_s1.n);
		nn  = crsc_pkg::word_t'(in_s1.nn);
		cmn = c - n;
		dout.cubic    = (nn - p) + (cmn <<< 1) + cmn;
		dout.square   = (p <<< 1) - (c <<< 2) - c + (n <<< 2) - nn;
		dout.linear   = n - p;
		dout.constant = c <<< 1;
	end

endmodule

FILE: sv/crsc_front.sv
// Point window, run count and job sequencer; issues up to three points per request.
// Depends on crsc_pkg.
module crsc_front #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [crsc_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tlast,
	input  logic [crsc_pkg::IDX_W-1:0]          first_index,
	input  logic [crsc_pkg::IDX_W-1:0]          last_index,
	output logic                                job_valid,
	input  logic                                job_ready,
	output crsc_pkg::job_ctrl_t                 job_ctrl,
	output crsc_pkg::lane_in_t                  job_lane [crsc_pkg::NCOMP]
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int RW = (CW > crsc_pkg::IDX_W) ? CW : crsc_pkg::IDX_W;

	typedef enum logic [1:0] {JOB_STEP, JOB_PREV, JOB_LAST} job_sel_t;

	crsc_pkg::coord_t w_q    [crsc_pkg::WIN_D][crsc_pkg::NCOMP];
	crsc_pkg::coord_t snap_q [crsc_pkg::WIN_D+1][crsc_pkg::NCOMP];
	crsc_pkg::coord_t wp     [crsc_pkg::WIN_D][crsc_pkg::NCOMP];
	crsc_pkg::coord_t cur    [crsc_pkg::NCOMP];
	logic                        snap_kept_q, dz0_q, dz1_q;
	logic [crsc_pkg::NJOB-1:0]   jobs_q, jobs_new, jobs_left, sel_bit;
	logic [crsc_pkg::IDX_W-1:0]  idx_q [crsc_pkg::NJOB];
	logic [CW-1:0]               seen_q, n_kept, n2, k0, k1, k2;
	logic                        accept, kept, close, roll;
	job_sel_t                    sel;

	function automatic logic in_range(input logic [CW-1:0] v,
		input logic [crsc_pkg::IDX_W-1:0] lo, input logic [crsc_pkg::IDX_W-1:0] hi);
		return (RW'(v) >= RW'(lo)) && (RW'(v) <= RW'(hi));
	endfunction

	always_comb begin
		for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
			cur[j] = s_tdata[j*crsc_pkg::COORD_W +: crsc_pkg::COORD_W];
		end
	end

	always_comb begin
		kept   = seen_q < CW'(MAX_POINTS);
		n_kept = seen_q + CW'(1);
		n2     = kept ? n_kept : seen_q;
		k0     = seen_q - CW'(2);
		k1     = n2 - CW'(2);
		k2     = n2 - CW'(1);
		close  = s_tlast && (n2 >= CW'(2));
		jobs_new[0] = kept && (seen_q >= CW'(2)) && in_range(k0, first_index, last_index);
		jobs_new[1] = close && in_range(k1, first_index, last_index);
		jobs_new[2] = close && in_range(k2, first_index, last_index);
	end

	// lowest pending job goes first
	always_comb begin
		if (jobs_q[0]) begin
			sel = JOB_STEP;
			sel_bit = 3'b001;
		end else if (jobs_q[1]) begin
			sel = JOB_PREV;
			sel_bit = 3'b010;
		end else begin
			sel = JOB_LAST;
			sel_bit = 3'b100;
		end
		job_valid     = |jobs_q;
		jobs_left     = jobs_q & ~(job_ready ? sel_bit : '0);
		s_tready      = (jobs_left == '0);
		accept        = s_tvalid && s_tready;
		job_ctrl.last = ((jobs_q & ~sel_bit) == '0);
		case (sel)
			JOB_STEP: job_ctrl.idx = idx_q[0];
			JOB_PREV: job_ctrl.idx = idx_q[1];
			default:  job_ctrl.idx = idx_q[2];
		endcase
	end

	// window as it stood after the request's own point
	always_comb begin
		for (int i = 0; i < crsc_pkg::WIN_D; i++) begin
			for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
				wp[i][j] = snap_kept_q ? snap_q[i+1][j] : snap_q[i][j];
			end
		end
	end

	always_comb begin
		roll = 1'b0;
		for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
			roll = (j == crsc_pkg::NCOMP - 1);
			case (sel)
				JOB_STEP: begin
					job_lane[j].p  = dz0_q ? crsc_pkg::ext2(snap_q[1][j], snap_q[2][j], roll)
					                       : crsc_pkg::sext(snap_q[0][j]);
					job_lane[j].c  = crsc_pkg::sext(snap_q[1][j]);
					job_lane[j].n  = crsc_pkg::sext(snap_q[2][j]);
					job_lane[j].nn = crsc_pkg::sext(snap_q[3][j]);
				end
				JOB_PREV: begin
					job_lane[j].p  = dz1_q ? crsc_pkg::ext2(wp[1][j], wp[2][j], roll)
					                       : crsc_pkg::sext(wp[0][j]);
					job_lane[j].c  = crsc_pkg::sext(wp[1][j]);
					job_lane[j].n  = crsc_pkg::sext(wp[2][j]);
					job_lane[j].nn = crsc_pkg::ext2(wp[2][j], wp[1][j], roll);
				end
				JOB_LAST: begin
					job_lane[j].p  = crsc_pkg::sext(wp[1][j]);
					job_lane[j].c  = crsc_pkg::sext(wp[2][j]);
					job_lane[j].n  = crsc_pkg::ext2(wp[2][j], wp[1][j], roll);
					job_lane[j].nn = crsc_pkg::ext3(wp[2][j], wp[1][j], roll);
				end
				default: begin
					job_lane[j] = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs_q <= '0;
			seen_q <= '0;
			for (int i = 0; i < crsc_pkg::WIN_D; i++) begin
				for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
					w_q[i][j] <= '0;
				end
			end
		end else if (accept) begin
			jobs_q <= jobs_new;
			if (s_tlast) begin
				seen_q <= '0;
				for (int i = 0; i < crsc_pkg::WIN_D; i++) begin
					for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
						w_q[i][j] <= '0;
					end
				end
			end else if (kept) begin
				seen_q <= n_kept;
				for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
					w_q[0][j] <= w_q[1][j];
					w_q[1][j] <= w_q[2][j];
					w_q[2][j] <= cur[j];
				end
			end
		end else begin
			jobs_q <= jobs_left;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
				for (int i = 0; i < crsc_pkg::WIN_D; i++) begin
					snap_q[i][j] <= w_q[i][j];
				end
				snap_q[crsc_pkg::WIN_D][j] <= cur[j];
			end
			snap_kept_q <= kept;
			dz0_q       <= (seen_q == CW'(2));
			dz1_q       <= (n2 == CW'(2));
			idx_q[0]    <= crsc_pkg::IDX_W'(k0);
			idx_q[1]    <= crsc_pkg::IDX_W'(k1);
			idx_q[2]    <= crsc_pkg::IDX_W'(k2);
		end
	end

endmodule

FILE: sv/crsc_merge.sv
// Merge stage: holds the four lane results of one point and sends them one per beat.
// Depends on crsc_pkg.
module crsc_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  crsc_pkg::job_ctrl_t                 in_ctrl,
	input  crsc_pkg::coef_t                     in_coef [crsc_pkg::NCOMP],
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [crsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [crsc_pkg::COMP_W-1:0]         m_tuser,
	output logic                                m_tlast
);

	crsc_pkg::coef_t       coef_q [crsc_pkg::NCOMP];
	crsc_pkg::coef_t       sel_coef;
	crsc_pkg::job_ctrl_t   ctrl_q;
	logic                  valid_q, fire, done;
	logic [crsc_pkg::COMP_W-1:0] beat_q;

	always_comb begin
		fire     = valid_q && m_tready;
		done     = fire && (beat_q == crsc_pkg::LAST_COMP);
		in_ready = !valid_q || done;
		sel_coef = coef_q[beat_q];
		m_tvalid = valid_q;
		m_tuser  = beat_q;
		m_tlast  = ctrl_q.last && (beat_q == crsc_pkg::LAST_COMP);
		m_tdata  = {{crsc_pkg::OUT_PAD_W{1'b0}}, sel_coef.constant, sel_coef.linear,
		            sel_coef.square, sel_coef.cubic, ctrl_q.idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
			beat_q  <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			beat_q <= beat_q + crsc_pkg::COMP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctrl_q <= in_ctrl;
			for (int j = 0; j < crsc_pkg::NCOMP; j++) begin
				coef_q[j] <= in_coef[j];
			end
		end
	end

endmodule

FILE: sv/catmull_rom_segment_coefficients_top.sv
// Catmull-Rom segment coefficient generator, top level.
// Uses crsc_pkg, crsc_front, crsc_lane and crsc_merge.
//
// Requests on the s_ side carry one control point: x, y, z and roll in
// signed Q12.12, with s_tlast marking the last point of a spline. Each point
// k is answered once point k+2 is in; the final point also answers the last
// two points, using extrapolated end points. Every answered point whose index
// lies in [first_index, last_index] gives four results on the m_ side, one
// per component (m_tuser 0 x, 1 y, 2 z, 3 roll), each with its cubic, square,
// linear and constant coefficient in Q.13. m_tlast marks the last result of
// a request. A request answers at most three points (twelve results).
// A result passes the job register, the lane stage and the merge register
// on its way out. The output channel moves one result per cycle while
// m_tready is high. The next request is taken while earlier results still
// drain. When m_tready is low the result holds and the pipeline fills, then
// s_tready drops. Reset empties the pipeline, clears the window and run
// count, and sets the index range to 0..63. The user must see that
// configuration is written only while no request is in flight; the block
// itself does not enforce it.
module catmull_rom_segment_coefficients_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [crsc_pkg::IN_TDATA_W-1:0]     s_tdata,  // pos_x, pos_y, pos_z, roll_angle
	input  logic                                s_tlast,  // final_point
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// point_index, cubic_coeff, square_coeff, linear_coeff, constant_coeff, zero pad
	output logic [crsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [crsc_pkg::COMP_W-1:0]         m_tuser,  // component
	output logic                                m_tlast,  // run_end
	input  logic                                cfg_we,
	input  logic [crsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [crsc_pkg::IDX_W-1:0] first_q, last_q;
	logic                       job_valid, job_ready, lane_load;
	logic                       s1_valid_q, merge_ready;
	crsc_pkg::job_ctrl_t        job_ctrl, ctrl_s1;
	crsc_pkg::lane_in_t         job_lane  [crsc_pkg::NCOMP];
	crsc_pkg::coef_t            lane_coef [crsc_pkg::NCOMP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= crsc_pkg::FIRST_RST;
			last_q  <= crsc_pkg::LAST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				crsc_pkg::REG_FIRST: first_q <= cfg_data;
				crsc_pkg::REG_LAST:  last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	crsc_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.first_index (first_q),
		.last_index  (last_q),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job_ctrl    (job_ctrl),
		.job_lane    (job_lane)
	);

	assign job_ready = !s1_valid_q || merge_ready;
	assign lane_load = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (job_ready) begin
			s1_valid_q <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_load) begin
			ctrl_s1 <= job_ctrl;
		end
	end

	for (genvar g = 0; g < crsc_pkg::NCOMP; g++) begin : g_lane
		crsc_lane u_lane (
			.clk  (clk),
			.en   (lane_load),
			.din  (job_lane[g]),
			.dout (lane_coef[g])
		);
	end

	crsc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s1_valid_q),
		.in_ready (merge_ready),
		.in_ctrl  (ctrl_s1),
		.in_coef  (lane_coef),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: sv/crsc_checker.sv
// Port checker for the Catmull-Rom coefficient block, bound to the top level.
// Depends on crsc_pkg and the assertion macro header.
`include "catmull_rom_segment_coefficients_top_macros.svh"

module crsc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [crsc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [crsc_pkg::COMP_W-1:0]      m_tuser,
	input logic                             m_tlast
);

	`CRSC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "result valid in reset")

	`CRSC_ASSERT_CLK(a_stall_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	`CRSC_ASSERT_CLK(a_last_on_roll, clk, arst_n, m_tvalid && m_tlast |-> m_tuser == crsc_pkg::LAST_COMP, "run end before last component")

	`CRSC_ASSERT_CLK(a_comp_burst, clk, arst_n, m_tvalid && m_tready && m_tuser != crsc_pkg::LAST_COMP |=> m_tvalid && m_tuser == $past(m_tuser) + 2'd1 && m_tdata[5:0] == $past(m_tdata[5:0]), "component burst broken")

endmodule

bind catmull_rom_segment_coefficients_top crsc_checker u_crsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
